// ===== rtl/core/pixel_to_view_angles_top_defines.svh =====
// Assertion macros for the pixel to view angles block.
// Define NO_ASSERTIONS to compile them out.
`ifndef PIXEL_TO_VIEW_ANGLES_TOP_DEFINES_SVH
`define PIXEL_TO_VIEW_ANGLES_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define PVA_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define PVA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PVA_ASSERT(lbl, ante, cons, msg)
`define PVA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/core/pva_pkg.sv =====
package pva_pkg;

    // field widths
    localparam int PX_W      = 12;
    localparam int DIM_W     = 13;
    localparam int FOV_W     = 16;
    localparam int AZ_W      = 17;
    localparam int EL_W      = 16;
    localparam int CFG_W     = 17;
    localparam int CFG_IDX_W = 3;

    // internal widths
    localparam int CX_W  = 14;  // centered pixel
    localparam int ANG_W = 28;  // degrees, 16 fraction bits
    localparam int SC_W  = 33;  // sine / cosine, Q30
    localparam int T_W   = 32;  // ray terms
    localparam int VW    = 34;  // vectoring datapath and multiplier operands
    localparam int MQ_W  = 38;  // rounded Q30 product

    // output angle format
    localparam int ANGLE_FRAC_BITS = 8;
    localparam int SH              = 16 - ANGLE_FRAC_BITS;

    localparam logic signed [ANG_W-1:0] FULL_Q16  = 28'sd23592960;
    localparam logic signed [ANG_W-1:0] HALF_Q16  = 28'sd11796480;
    localparam logic signed [ANG_W-1:0] QUART_Q16 = 28'sd5898240;
    localparam logic signed [VW-1:0]    KINV_Q30  = 34'sd652032875;

    localparam int AZ_FULL = 360 << ANGLE_FRAC_BITS;
    localparam int EL_MAX  = 90 << ANGLE_FRAC_BITS;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCREEN_WIDTH   = 3'd0,
        CFG_SCREEN_HEIGHT  = 3'd1,
        CFG_VIEW_AZIMUTH   = 3'd2,
        CFG_VIEW_ELEVATION = 3'd3,
        CFG_VERTICAL_FOV   = 3'd4
    } cfg_index_t;

    // rotation-mode CORDIC slice
    typedef struct packed {
        logic signed [SC_W-1:0]  x;
        logic signed [SC_W-1:0]  y;
        logic signed [ANG_W-1:0] z;
        logic                    flip;
    } rot_t;

    // vectoring-mode CORDIC slice
    typedef struct packed {
        logic signed [VW-1:0]    x;
        logic signed [VW-1:0]    y;
        logic signed [ANG_W-1:0] z;
    } vec_t;

    // center-pixel bypass carried along the pipe
    typedef struct packed {
        logic                   center;
        logic [AZ_W-1:0]        cen_az;
        logic signed [EL_W-1:0] cen_el;
    } side_t;

    // atan(2^-i) in Q16 degrees
    function automatic logic signed [ANG_W-1:0] atan_q16(input int i);
        case (i)
            0:       return 28'sd2949120;
            1:       return 28'sd1740967;
            2:       return 28'sd919879;
            3:       return 28'sd466945;
            4:       return 28'sd234379;
            5:       return 28'sd117304;
            6:       return 28'sd58666;
            7:       return 28'sd29335;
            8:       return 28'sd14668;
            9:       return 28'sd7334;
            10:      return 28'sd3667;
            11:      return 28'sd1833;
            12:      return 28'sd917;
            13:      return 28'sd458;
            14:      return 28'sd229;
            15:      return 28'sd115;
            16:      return 28'sd57;
            17:      return 28'sd29;
            18:      return 28'sd14;
            19:      return 28'sd7;
            20:      return 28'sd4;
            21:      return 28'sd2;
            22:      return 28'sd1;
            default: return '0;
        endcase
    endfunction

    // Q30 product, rounded half away from zero
    function automatic logic signed [MQ_W-1:0] mulq(input logic signed [VW-1:0] a,
                                                    input logic signed [VW-1:0] b);
        logic            neg;
        logic [VW-1:0]   ua;
        logic [VW-1:0]   ub;
        logic [2*VW-1:0] p;
        logic [MQ_W-1:0] r;
        neg = a[VW-1] ^ b[VW-1];
        ua  = a[VW-1] ? (~a + 1'b1) : a;
        ub  = b[VW-1] ? (~b + 1'b1) : b;
        p   = (2*VW)'(ua) * (2*VW)'(ub);
        p   = p + ((2*VW)'(1) << 29);
        r   = MQ_W'(p >> 30);
        return neg ? -$signed(r) : $signed(r);
    endfunction

    // fold an angle into +-90 degrees; flip marks a half-turn taken out
    function automatic rot_t rot_init(input logic signed [ANG_W-1:0] ang,
                                      input logic signed [SC_W-1:0]  x0);
        rot_t                    o;
        logic signed [ANG_W-1:0] a;
        a = ang;
        if (a > HALF_Q16) a = a - FULL_Q16;
        if (a <= -HALF_Q16) a = a + FULL_Q16;
        o.flip = 1'b0;
        if (a > QUART_Q16)
        begin
            a      = a - HALF_Q16;
            o.flip = 1'b1;
        end
        else if (a < -QUART_Q16)
        begin
            a      = a + HALF_Q16;
            o.flip = 1'b1;
        end
        o.x = x0;
        o.y = '0;
        o.z = a;
        return o;
    endfunction

    function automatic rot_t rot_step(input rot_t r, input int i);
        rot_t                   o;
        logic signed [SC_W-1:0] xs;
        logic signed [SC_W-1:0] ys;
        xs     = $signed(r.x) >>> i;
        ys     = $signed(r.y) >>> i;
        o.flip = r.flip;
        if (!r.z[ANG_W-1])
        begin
            o.x = r.x - ys;
            o.y = r.y + xs;
            o.z = r.z - atan_q16(i);
        end
        else
        begin
            o.x = r.x + ys;
            o.y = r.y - xs;
            o.z = r.z + atan_q16(i);
        end
        return o;
    endfunction

    // quarter-turn pre-rotation into the right half plane
    function automatic vec_t vec_init(input logic signed [VW-1:0] x,
                                      input logic signed [VW-1:0] y);
        vec_t o;
        o.x = x;
        o.y = y;
        o.z = '0;
        if (x[VW-1])
        begin
            if (!y[VW-1])
            begin
                o.x = y;
                o.y = -x;
                o.z = QUART_Q16;
            end
            else
            begin
                o.x = -y;
                o.y = x;
                o.z = -QUART_Q16;
            end
        end
        return o;
    endfunction

    function automatic vec_t vec_step(input vec_t v, input int i);
        vec_t                 o;
        logic signed [VW-1:0] xs;
        logic signed [VW-1:0] ys;
        xs = $signed(v.x) >>> i;
        ys = $signed(v.y) >>> i;
        o  = v;
        if (!v.y[VW-1] && (v.y != '0))
        begin
            o.x = v.x + ys;
            o.y = v.y - xs;
            o.z = v.z + atan_q16(i);
        end
        else if (v.y[VW-1])
        begin
            o.x = v.x - ys;
            o.y = v.y + xs;
            o.z = v.z - atan_q16(i);
        end
        return o;
    endfunction

endpackage

// ===== rtl/core/pva_if.sv =====
// pixel item channel
interface pva_pixel_if;
    import pva_pkg::*;
    logic            valid;
    logic            ready;
    logic [PX_W-1:0] pixel_x;
    logic [PX_W-1:0] pixel_y;
    modport source (output valid, output pixel_x, output pixel_y, input ready);
    modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

// view angle item channel
interface pva_angle_if;
    import pva_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [AZ_W-1:0]        out_azimuth;
    logic signed [EL_W-1:0] out_elevation;
    modport source (output valid, output out_azimuth, output out_elevation, input ready);
    modport sink   (input valid, input out_azimuth, input out_elevation, output ready);
endinterface

// ===== rtl/core/pixel_to_view_angles_top.sv =====
// Channel     Dir  Item                          Width
// pixel_in    in   pixel_x, pixel_y              12 + 12 unsigned
// angle_out   out  out_azimuth, out_elevation    17 unsigned + 16 signed
// cfg_*       in   register write, index 0..4    17 data, 3 index
//
// One item enters per cycle while the output skid register is empty.
// The pipe is three CORDIC chains in series: sine/cosine, then
// two atan2 passes, one iteration per stage, plus ten single stages for
// entry, folding, products and magnitude, then the output register.
// rst_n clears valids and restores register defaults; no clearing pass.
// A stalled output parks one item in a skid register; input ready drops
// only while that register is full, so no item is lost or repeated.
`include "pixel_to_view_angles_top_defines.svh"

module pixel_to_view_angles_top #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [pva_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pva_pkg::CFG_W-1:0]     cfg_data,
    pva_pixel_if.sink                     pixel_in,
    pva_angle_if.source                   angle_out
);
    import pva_pkg::*;

    localparam int N   = CORDIC_STAGES;
    localparam int LAT = 3 * N + 10;

    localparam logic signed [ANG_W:0] RND_ANG   = (ANG_W+1)'(1) <<< (SH - 1);
    localparam logic signed [ANG_W:0] AZ_FULL_S = (ANG_W+1)'(AZ_FULL);
    localparam logic signed [ANG_W:0] EL_MAX_S  = (ANG_W+1)'(EL_MAX);

    // configuration registers
    logic [DIM_W-1:0]       sw_reg;
    logic [DIM_W-1:0]       sh_reg;
    logic [AZ_W-1:0]        va_reg;
    logic signed [EL_W-1:0] ve_reg;
    logic [FOV_W-1:0]       fov_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sw_reg  <= 13'd640;
            sh_reg  <= 13'd480;
            va_reg  <= '0;
            ve_reg  <= '0;
            fov_reg <= 16'd15360;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_SCREEN_WIDTH:   sw_reg  <= cfg_data[DIM_W-1:0];
                CFG_SCREEN_HEIGHT:  sh_reg  <= cfg_data[DIM_W-1:0];
                CFG_VIEW_AZIMUTH:   va_reg  <= cfg_data[AZ_W-1:0];
                CFG_VIEW_ELEVATION: ve_reg  <= cfg_data[EL_W-1:0];
                CFG_VERTICAL_FOV:   fov_reg <= cfg_data[FOV_W-1:0];
                default: ;
            endcase
        end
    end

    // pipeline state
    logic                    adv;
    logic                    vld_reg [0:LAT-1];
    side_t                   side_reg [0:LAT-1];
    logic signed [CX_W-1:0]  px_reg [0:N+1];
    logic signed [CX_W-1:0]  py_reg [0:N+1];
    logic signed [ANG_W-1:0] fov_ang_reg;
    logic signed [ANG_W-1:0] az_ang_reg;
    logic signed [ANG_W-1:0] el_ang_reg;
    rot_t                    rf_reg [0:N];
    rot_t                    ra_reg [0:N];
    rot_t                    re_reg [0:N];
    rot_t                    rf_next [1:N];
    rot_t                    ra_next [1:N];
    rot_t                    re_next [1:N];
    logic signed [SC_W-1:0]  sf_reg, cf_reg, saz0_reg, caz0_reg, sel0_reg, cel0_reg;
    logic signed [CX_W-1:0]  px0_reg, py0_reg;
    logic signed [T_W-1:0]   d_reg, xs_reg, ys_reg;
    logic signed [SC_W-1:0]  saz1_reg, caz1_reg, sel1_reg, cel1_reg;
    logic signed [T_W-1:0]   dc_reg, ysl_reg, tya_reg, tyb_reg, xs2_reg;
    logic signed [SC_W-1:0]  saz2_reg, caz2_reg;
    logic signed [T_W-1:0]   m1_reg, m2_reg, m3_reg, m4_reg, m5_reg, m6_reg, ty3_reg;
    logic signed [T_W-1:0]   tx_reg, tz_reg, ty4_reg;
    vec_t                    v1_reg [0:N];
    vec_t                    v1_next [1:N];
    logic signed [T_W-1:0]   tyv_reg [0:N];
    logic signed [T_W-1:0]   mag_reg, tym_reg;
    logic [AZ_W-1:0]         azm_reg;
    vec_t                    v2_reg [0:N];
    vec_t                    v2_next [1:N];
    logic [AZ_W-1:0]         azv_reg [0:N];

    // entry stage arithmetic
    logic signed [CX_W-1:0]  cx, cy;
    logic signed [ANG_W-1:0] az_q;
    side_t                   side_in;
    logic signed [47:0]      d_prod;
    logic signed [47:0]      xs_prod;
    logic signed [47:0]      ys_prod;
    logic signed [ANG_W:0]   az_sum;
    logic [AZ_W-1:0]         az_sat;
    logic signed [ANG_W:0]   el_sum;
    logic signed [EL_W-1:0]  el_sat;
    logic [AZ_W-1:0]         res_az;
    logic signed [EL_W-1:0]  res_el;

    always_comb
    begin
        cx = $signed({2'b00, pixel_in.pixel_x}) - $signed({2'b00, sw_reg[DIM_W-1:1]});
        cy = $signed({2'b00, pixel_in.pixel_y}) - $signed({2'b00, sh_reg[DIM_W-1:1]});
        // view azimuth taken once around the circle
        az_q = ANG_W'(va_reg) <<< SH;
        if (az_q >= FULL_Q16) az_q = az_q - FULL_Q16;
        side_in.center = (cx == '0) && (cy == '0);
        side_in.cen_az = (va_reg >= AZ_W'(AZ_FULL)) ? va_reg - AZ_W'(AZ_FULL) : va_reg;
        if (ve_reg > EL_W'(EL_MAX))
            side_in.cen_el = EL_W'(EL_MAX);
        else if (ve_reg < -EL_W'(EL_MAX))
            side_in.cen_el = -EL_W'(EL_MAX);
        else
            side_in.cen_el = ve_reg;
    end

    // one CORDIC iteration per stage
    always_comb
    begin
        for (int k = 1; k <= N; k++)
        begin
            rf_next[k] = rot_step(rf_reg[k-1], k - 1);
            ra_next[k] = rot_step(ra_reg[k-1], k - 1);
            re_next[k] = rot_step(re_reg[k-1], k - 1);
            v1_next[k] = vec_step(v1_reg[k-1], k - 1);
            v2_next[k] = vec_step(v2_reg[k-1], k - 1);
        end
    end

    // focal term and pixel terms scaled by 2 sin(fov/2)
    always_comb
    begin
        d_prod  = 48'($signed({1'b0, sh_reg})) * 48'(cf_reg);
        xs_prod = (48'(px0_reg) * 48'(sf_reg)) <<< 1;
        ys_prod = (48'(py0_reg) * 48'(sf_reg)) <<< 1;
    end

    // azimuth after the first atan2, saturated to 0..360 degrees
    always_comb
    begin
        az_sum = ((ANG_W+1)'(v1_reg[N].z) + (ANG_W+1)'(HALF_Q16) + RND_ANG) >>> SH;
        if (az_sum[ANG_W])
            az_sat = '0;
        else if (az_sum > AZ_FULL_S)
            az_sat = AZ_W'(AZ_FULL);
        else
            az_sat = az_sum[AZ_W-1:0];
    end

    // elevation after the second atan2, saturated to +-90 degrees; center pixels use the bypass
    always_comb
    begin
        el_sum = ((ANG_W+1)'(v2_reg[N].z) + RND_ANG) >>> SH;
        if (el_sum > EL_MAX_S)
            el_sat = EL_W'(EL_MAX);
        else if (el_sum < -EL_MAX_S)
            el_sat = -EL_W'(EL_MAX);
        else
            el_sat = el_sum[EL_W-1:0];
        res_az = side_reg[LAT-1].center ? side_reg[LAT-1].cen_az : azv_reg[N];
        res_el = side_reg[LAT-1].center ? side_reg[LAT-1].cen_el : el_sat;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < LAT; k++)
                vld_reg[k] <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[0] <= pixel_in.valid;
            for (int k = 1; k < LAT; k++)
                vld_reg[k] <= vld_reg[k-1];
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0] <= side_in;
            for (int k = 1; k < LAT; k++)
                side_reg[k] <= side_reg[k-1];

            // entry
            px_reg[0]   <= cx;
            py_reg[0]   <= cy;
            fov_ang_reg <= ANG_W'(fov_reg) <<< (SH - 1);
            az_ang_reg  <= az_q;
            el_ang_reg  <= ANG_W'(ve_reg) <<< SH;
            for (int k = 1; k <= N + 1; k++)
            begin
                px_reg[k] <= px_reg[k-1];
                py_reg[k] <= py_reg[k-1];
            end

            // sine / cosine chains
            rf_reg[0] <= rot_init(fov_ang_reg, SC_W'(KINV_Q30));
            ra_reg[0] <= rot_init(az_ang_reg, SC_W'(KINV_Q30));
            re_reg[0] <= rot_init(el_ang_reg, SC_W'(KINV_Q30));
            for (int k = 1; k <= N; k++)
            begin
                rf_reg[k] <= rf_next[k];
                ra_reg[k] <= ra_next[k];
                re_reg[k] <= re_next[k];
            end

            // undo the half-turn fold
            sf_reg   <= rf_reg[N].flip ? -rf_reg[N].y : rf_reg[N].y;
            cf_reg   <= rf_reg[N].flip ? -rf_reg[N].x : rf_reg[N].x;
            saz0_reg <= ra_reg[N].flip ? -ra_reg[N].y : ra_reg[N].y;
            caz0_reg <= ra_reg[N].flip ? -ra_reg[N].x : ra_reg[N].x;
            sel0_reg <= re_reg[N].flip ? -re_reg[N].y : re_reg[N].y;
            cel0_reg <= re_reg[N].flip ? -re_reg[N].x : re_reg[N].x;
            px0_reg  <= px_reg[N+1];
            py0_reg  <= py_reg[N+1];

            // ray in camera frame
            d_reg    <= T_W'((d_prod + 48'sd32768) >>> 16);
            xs_reg   <= T_W'((xs_prod + 48'sd32768) >>> 16);
            ys_reg   <= T_W'((ys_prod + 48'sd32768) >>> 16);
            saz1_reg <= saz0_reg;
            caz1_reg <= caz0_reg;
            sel1_reg <= sel0_reg;
            cel1_reg <= cel0_reg;

            // elevation rotation
            dc_reg   <= T_W'(mulq(VW'(d_reg), VW'(cel1_reg)));
            ysl_reg  <= T_W'(mulq(VW'(ys_reg), VW'(sel1_reg)));
            tya_reg  <= T_W'(mulq(VW'(d_reg), VW'(sel1_reg)));
            tyb_reg  <= T_W'(mulq(VW'(ys_reg), VW'(cel1_reg)));
            xs2_reg  <= xs_reg;
            saz2_reg <= saz1_reg;
            caz2_reg <= caz1_reg;

            // azimuth rotation products
            m1_reg  <= T_W'(mulq(VW'(dc_reg), VW'(saz2_reg)));
            m2_reg  <= T_W'(mulq(VW'(xs2_reg), VW'(caz2_reg)));
            m3_reg  <= T_W'(mulq(VW'(ysl_reg), VW'(saz2_reg)));
            m4_reg  <= T_W'(mulq(VW'(dc_reg), VW'(caz2_reg)));
            m5_reg  <= T_W'(mulq(VW'(xs2_reg), VW'(saz2_reg)));
            m6_reg  <= T_W'(mulq(VW'(ysl_reg), VW'(caz2_reg)));
            ty3_reg <= tya_reg - tyb_reg;

            tx_reg  <= m1_reg + m2_reg + m3_reg;
            tz_reg  <= m5_reg - m4_reg - m6_reg;
            ty4_reg <= ty3_reg;

            // first atan2 on (tz, -tx)
            v1_reg[0]  <= vec_init(VW'(tz_reg), -VW'(tx_reg));
            tyv_reg[0] <= ty4_reg;
            for (int k = 1; k <= N; k++)
            begin
                v1_reg[k]  <= v1_next[k];
                tyv_reg[k] <= tyv_reg[k-1];
            end

            // horizontal magnitude with gain removed
            mag_reg <= T_W'(mulq(v1_reg[N].x, KINV_Q30));
            azm_reg <= az_sat;
            tym_reg <= tyv_reg[N];

            // second atan2 on (magnitude, ty)
            v2_reg[0]  <= vec_init(VW'(mag_reg), VW'(tym_reg));
            azv_reg[0] <= azm_reg;
            for (int k = 1; k <= N; k++)
            begin
                v2_reg[k]  <= v2_next[k];
                azv_reg[k] <= azv_reg[k-1];
            end
        end
    end

    // output register with one-item skid
    logic                   out_valid_reg;
    logic                   skid_valid_reg;
    logic [AZ_W-1:0]        out_az_reg;
    logic signed [EL_W-1:0] out_el_reg;
    logic [AZ_W-1:0]        skid_az_reg;
    logic signed [EL_W-1:0] skid_el_reg;
    logic                   push;
    logic                   pop;

    assign adv   = ~skid_valid_reg;
    assign push  = adv & vld_reg[LAT-1];
    assign pop   = out_valid_reg & angle_out.ready;

    assign pixel_in.ready          = adv;
    assign angle_out.valid         = out_valid_reg;
    assign angle_out.out_azimuth   = out_az_reg;
    assign angle_out.out_elevation = out_el_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
                skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
                skid_valid_reg <= 1'b1;
            else
                out_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_az_reg <= skid_az_reg;
                out_el_reg <= skid_el_reg;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_az_reg <= res_az;
                skid_el_reg <= res_el;
            end
            else
            begin
                out_az_reg <= res_az;
                out_el_reg <= res_el;
            end
        end
    end

    // checks
    `PVA_ASSERT(skid_implies_out, skid_valid_reg, out_valid_reg, "skid full with output empty")
    `PVA_ASSERT(skid_fill_on_stall, $rose(skid_valid_reg), $past(out_valid_reg && !angle_out.ready), "skid filled without a stall")
    `PVA_ASSERT(result_in_range, angle_out.valid, (angle_out.out_azimuth <= AZ_W'(AZ_FULL)) && (angle_out.out_elevation <= EL_W'(EL_MAX)) && (angle_out.out_elevation >= -EL_W'(EL_MAX)), "result out of range")

endmodule

// ===== sim/tb_pixel_to_view_angles_top.sv =====
`timescale 1ns / 1ps

module tb_pixel_to_view_angles_top;
    import pva_pkg::*;

    localparam int       PIPE_DEPTH  = 3 * 16 + 11;
    localparam int       CYCLE_LIMIT = 400000;
    localparam longint   FULL_DEG    = 64'sd23592960;
    localparam longint   KINV        = 64'sd652032875;
    localparam longint   ATAN_TAB [0:15] = '{2949120, 1740967, 919879, 466945, 234379,
        117304, 58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};

    typedef struct {
        logic [AZ_W-1:0]        az;
        logic signed [EL_W-1:0] el;
    } view_item_t;

    logic clk;
    logic rst_n;
    logic cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    pva_pixel_if pix_ch ();
    pva_angle_if ang_ch ();

    pixel_to_view_angles_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pixel_in  (pix_ch),
        .angle_out (ang_ch)
    );

    // shadow registers
    logic [DIM_W-1:0]       sh_width;
    logic [DIM_W-1:0]       sh_height;
    logic [AZ_W-1:0]        sh_az;
    logic signed [EL_W-1:0] sh_el;
    logic [FOV_W-1:0]       sh_fov;

    view_item_t expected_angles[$];
    int mismatches;
    int pixels_sent;
    int angles_checked;
    int burst_left;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("pixel_to_view_angles_top regression: fail");
        $finish;
    end

    function automatic longint round_shift(input longint v, input int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    // Q30 product, rounded half away from zero
    function automatic longint qmul(input longint a, input longint b);
        longint unsigned ua;
        longint unsigned ub;
        longint unsigned r;
        ua = (a < 0) ? -a : a;
        ub = (b < 0) ? -b : b;
        r  = (ua * ub + (64'd1 << 29)) >> 30;
        return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
    endfunction

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    task automatic sine_cosine(input longint ang, output longint sn, output longint cs);
        longint a;
        longint x;
        longint y;
        longint t;
        bit     flip;
        a    = ang % FULL_DEG;
        x    = KINV;
        y    = 0;
        flip = 0;
        if (a > FULL_DEG / 2) a -= FULL_DEG;
        if (a <= -FULL_DEG / 2) a += FULL_DEG;
        if (a > FULL_DEG / 4)
        begin
            a -= FULL_DEG / 2;
            flip = 1;
        end
        else if (a < -FULL_DEG / 4)
        begin
            a += FULL_DEG / 2;
            flip = 1;
        end
        for (int i = 0; i < 16; i++)
        begin
            t = x;
            if (a >= 0)
            begin
                x -= y >>> i;
                y += t >>> i;
                a -= ATAN_TAB[i];
            end
            else
            begin
                x += y >>> i;
                y -= t >>> i;
                a += ATAN_TAB[i];
            end
        end
        sn = flip ? -y : y;
        cs = flip ? -x : x;
    endtask

    // angle of (x, y) in Q16 degrees plus gain-corrected magnitude
    task automatic vector_angle(input longint xi, input longint yi,
                                output longint z, output longint mag);
        longint x;
        longint y;
        longint t;
        x = xi;
        y = yi;
        z = 0;
        if (x < 0)
        begin
            t = x;
            if (y >= 0)
            begin
                x = y;
                y = -t;
                z = FULL_DEG / 4;
            end
            else
            begin
                x = -y;
                y = t;
                z = -FULL_DEG / 4;
            end
        end
        for (int i = 0; i < 16; i++)
        begin
            t = x;
            if (y > 0)
            begin
                x += y >>> i;
                y -= t >>> i;
                z += ATAN_TAB[i];
            end
            else if (y < 0)
            begin
                x -= y >>> i;
                y += t >>> i;
                z -= ATAN_TAB[i];
            end
        end
        mag = qmul(x, KINV);
    endtask

    task automatic predict_angles(input logic [PX_W-1:0] px, input logic [PX_W-1:0] py,
                                  output view_item_t res);
        longint x, y, vel, az, el;
        longint sf, cf, saz, caz, sel, cel;
        longint d, xs, ys, dc, ysl, tx, ty, tz, mag, a, dummy;
        x   = longint'(px) - longint'(sh_width >> 1);
        y   = longint'(py) - longint'(sh_height >> 1);
        vel = longint'(sh_el);
        if (x == 0 && y == 0)
        begin
            az = longint'(sh_az) % AZ_FULL;
            el = clamp(vel, -EL_MAX, EL_MAX);
        end
        else
        begin
            sine_cosine(longint'(sh_fov) * 256 / 2, sf, cf);
            sine_cosine(longint'(sh_az) * 256, saz, caz);
            sine_cosine(vel * 256, sel, cel);
            d   = round_shift(longint'(sh_height) * cf, 16);
            xs  = round_shift(2 * x * sf, 16);
            ys  = round_shift(2 * y * sf, 16);
            dc  = qmul(d, cel);
            ysl = qmul(ys, sel);
            tx  = qmul(dc, saz) + qmul(xs, caz) + qmul(ysl, saz);
            ty  = qmul(d, sel) - qmul(ys, cel);
            tz  = -qmul(dc, caz) + qmul(xs, saz) - qmul(ysl, caz);
            vector_angle(tz, -tx, a, mag);
            az  = clamp(round_shift(a + FULL_DEG / 2, SH), 0, AZ_FULL);
            vector_angle(mag, ty, a, dummy);
            el  = clamp(round_shift(a, SH), -EL_MAX, EL_MAX);
        end
        res.az = az[AZ_W-1:0];
        res.el = el[EL_W-1:0];
    endtask

    // register write, only while idle
    task automatic write_reg(input cfg_index_t idx, input logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(posedge clk);
        case (idx)
            CFG_SCREEN_WIDTH:   sh_width  = val[DIM_W-1:0];
            CFG_SCREEN_HEIGHT:  sh_height = val[DIM_W-1:0];
            CFG_VIEW_AZIMUTH:   sh_az     = val[AZ_W-1:0];
            CFG_VIEW_ELEVATION: sh_el     = val[EL_W-1:0];
            CFG_VERTICAL_FOV:   sh_fov    = val[FOV_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_write = 1'b0;
    endtask

    task automatic write_all(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                             input logic [CFG_W-1:0] az, input logic [CFG_W-1:0] el,
                             input logic [CFG_W-1:0] fov);
        write_reg(CFG_SCREEN_WIDTH, w);
        write_reg(CFG_SCREEN_HEIGHT, h);
        write_reg(CFG_VIEW_AZIMUTH, az);
        write_reg(CFG_VIEW_ELEVATION, el);
        write_reg(CFG_VERTICAL_FOV, fov);
    endtask

    // send one pixel item; bursts separated by random gaps
    task automatic send_pixel(input logic [PX_W-1:0] px, input logic [PX_W-1:0] py);
        view_item_t exp_item;
        int         gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
            repeat (gap)
            begin
                @(negedge clk);
                pix_ch.valid = 1'b0;
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        @(negedge clk);
        pix_ch.valid   = 1'b1;
        pix_ch.pixel_x = px;
        pix_ch.pixel_y = py;
        do
            @(posedge clk);
        while (!pix_ch.ready);
        predict_angles(px, py, exp_item);
        expected_angles.push_back(exp_item);
        pixels_sent++;
    endtask

    task automatic drain();
        @(negedge clk);
        pix_ch.valid = 1'b0;
        while (expected_angles.size() != 0) @(posedge clk);
        repeat (PIPE_DEPTH + 10) @(posedge clk);
    endtask

    // receiver stall pattern: free-running, random, long stalls
    initial
    begin
        int mode;
        int cnt;
        ang_ch.ready = 1'b0;
        mode = 0;
        cnt  = 0;
        forever
        begin
            @(negedge clk);
            cnt++;
            if (cnt % 80 == 0) mode = $urandom_range(0, 2);
            case (mode)
                0:       ang_ch.ready = 1'b1;
                1:       ang_ch.ready = ($urandom_range(0, 3) != 0);
                default: ang_ch.ready = ((cnt % 24) >= 9);
            endcase
        end
    end

    // result checker
    initial
    begin
        view_item_t exp_item;
        forever
        begin
            @(posedge clk);
            if (rst_n && ang_ch.valid && ang_ch.ready)
            begin
                if (expected_angles.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected item: az=%0d el=%0d",
                                 ang_ch.out_azimuth, ang_ch.out_elevation);
                end
                else
                begin
                    exp_item = expected_angles.pop_front();
                    if (ang_ch.out_azimuth !== exp_item.az ||
                        ang_ch.out_elevation !== exp_item.el)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch #%0d: az exp %0d got %0d, el exp %0d got %0d",
                                     angles_checked, exp_item.az, ang_ch.out_azimuth,
                                     exp_item.el, ang_ch.out_elevation);
                    end
                end
                angles_checked++;
            end
        end
    end

    // corners, center and edges at reset settings
    task automatic test_directed();
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd320, 12'd240);
        send_pixel(12'd0, 12'd4095);
        send_pixel(12'd4095, 12'd0);
        send_pixel(12'd319, 12'd240);
        send_pixel(12'd320, 12'd239);
        send_pixel(12'd639, 12'd479);
        send_pixel(12'd2730, 12'd1365);
        drain();
    endtask

    // center and non-center pixels with extreme view angles
    task automatic test_center_bypass();
        write_all(17'd1, 17'd1, 17'd92159, 17'h1A600, 17'd256);   // -23040
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd1, 12'd0);
        drain();
        write_all(17'd4096, 17'd4096, 17'h1FFFF, 17'd23040, 17'd45824);
        send_pixel(12'd2048, 12'd2048);
        send_pixel(12'd4095, 12'd4095);
        drain();
        write_reg(CFG_VIEW_ELEVATION, 17'h07FFF);
        send_pixel(12'd2048, 12'd2048);
        send_pixel(12'd0, 12'd2048);
        drain();
        write_reg(CFG_VIEW_ELEVATION, 17'h08000);
        send_pixel(12'd2048, 12'd2048);
        send_pixel(12'd2048, 12'd0);
        drain();
    endtask

    // zero fov, odd and zero screen sizes, oversize fields
    task automatic test_odd_settings();
        write_all(17'd0, 17'd0, 17'd46080, 17'd0, 17'd0);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd100, 12'd3000);
        drain();
        write_all(17'h1FFF, 17'h1FFF, 17'd0, 17'd0, 17'hFFFF);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd1234, 12'd3210);
        drain();
    endtask

    // random settings and pixels
    task automatic test_random_views();
        logic [CFG_W-1:0] w, h;
        for (int ph = 0; ph < 10; ph++)
        begin
            if (ph % 3 == 0)
            begin
                w = 17'($urandom_range(0, 17'h1FFFF));
                h = 17'($urandom_range(0, 17'h1FFFF));
            end
            else
            begin
                w = 17'($urandom_range(1, 4096));
                h = 17'($urandom_range(1, 4096));
            end
            write_all(w, h,
                      17'((ph % 4 == 0) ? $urandom_range(0, 17'h1FFFF)
                                        : $urandom_range(0, 92159)),
                      17'((ph % 4 == 1) ? $urandom_range(0, 17'h1FFFF)
                                        : 17'(16'($signed($urandom_range(0, 46080)) - 23040))),
                      17'((ph % 4 == 2) ? $urandom_range(0, 17'h1FFFF)
                                        : $urandom_range(256, 45824)));
            for (int k = 0; k < 55; k++)
            begin
                if ($urandom_range(0, 19) == 0)
                    send_pixel(12'(sh_width >> 1), 12'(sh_height >> 1));
                else if ($urandom_range(0, 2) == 0)
                    send_pixel(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
                else
                    send_pixel(12'($urandom_range(0, (sh_width > 4096) ? 4095 : sh_width)),
                               12'($urandom_range(0, (sh_height > 4096) ? 4095 : sh_height)));
            end
            drain();
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cfg_write      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        pix_ch.valid   = 1'b0;
        pix_ch.pixel_x = '0;
        pix_ch.pixel_y = '0;
        sh_width       = 13'd640;
        sh_height      = 13'd480;
        sh_az          = '0;
        sh_el          = '0;
        sh_fov         = 16'd15360;
        mismatches     = 0;
        pixels_sent    = 0;
        angles_checked = 0;
        burst_left     = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_center_bypass();
        test_odd_settings();
        test_random_views();

        $display("covered %0d pixels, %0d view angle items checked, %0d mismatches",
                 pixels_sent, angles_checked, mismatches);
        $display("settings swept: screen sizes 0..8191, fov 0..65535, full view angle range");
        if (mismatches == 0 && expected_angles.size() == 0)
            $display("pixel_to_view_angles_top regression: pass");
        else
            $display("pixel_to_view_angles_top regression: fail");
        $finish;
    end

endmodule

// ===== pixel_to_view_angles_top.f =====
+incdir+rtl/core
rtl/core/pva_pkg.sv
rtl/core/pva_if.sv
rtl/core/pixel_to_view_angles_top.sv
sim/tb_pixel_to_view_angles_top.sv
